// ===== rtl/uafc_pkg.sv =====
// Package for the UBX acknowledge frame checker.
// Holds sync constants, status codes, register map and the config struct.
// No dependencies.
package uafc_pkg;

    // Sync bytes and minimum frame length
    localparam logic [7:0] SYNC_FIRST    = 8'hB5;
    localparam logic [7:0] SYNC_SECOND   = 8'h62;
    localparam int         MIN_FRAME_LEN = 8;
    localparam int         POS_W         = 4;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Status codes of one result word
    typedef enum logic [2:0] {
        ST_ACK      = 3'd0,
        ST_NAK      = 3'd1,
        ST_NOT_UBX  = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_CLASS    = 3'd4,
        ST_ID       = 3'd5
    } status_t;

    // Register map (word index)
    localparam int ADDR_W = 4;
    typedef enum logic [1:0] {
        REG_ACK_CLASS = 2'd0,
        REG_ACK_ID    = 2'd1,
        REG_NAK_ID    = 2'd2
    } reg_idx_t;

    // Reset values of the registers
    localparam logic [7:0] ACK_CLASS_RST = 8'd5;
    localparam logic [7:0] ACK_ID_RST    = 8'd1;
    localparam logic [7:0] NAK_ID_RST    = 8'd0;

    // Configuration handed from the register file to the frame logic
    typedef struct packed {
        logic [7:0] ack_class;
        logic [7:0] ack_id;
        logic [7:0] nak_id;
    } cfg_t;

endpackage

// ===== rtl/uafc_regs.sv =====
// APB register file of the UBX acknowledge frame checker.
// Depends on uafc_pkg for the register map and config struct.
module uafc_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uafc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output uafc_pkg::cfg_t                cfg
);
    import uafc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_class <= ACK_CLASS_RST;
            cfg_reg.ack_id    <= ACK_ID_RST;
            cfg_reg.nak_id    <= NAK_ID_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_ACK_CLASS: cfg_reg.ack_class <= pwdata[7:0];
                REG_ACK_ID:    cfg_reg.ack_id    <= pwdata[7:0];
                REG_NAK_ID:    cfg_reg.nak_id    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux; unmapped addresses read zero
    always_comb begin
        unique case (idx)
            REG_ACK_CLASS: prdata = {24'd0, cfg_reg.ack_class};
            REG_ACK_ID:    prdata = {24'd0, cfg_reg.ack_id};
            REG_NAK_ID:    prdata = {24'd0, cfg_reg.nak_id};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/uafc_frame.sv =====
// Per-byte frame tracking and status decision for the UBX ack checker.
// Runs the Fletcher sums with a two-byte hold line. Depends on uafc_pkg.
module uafc_frame (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_en,
    input  logic [7:0]          rx_byte,
    input  logic                end_of_frame,
    input  uafc_pkg::cfg_t      cfg,
    output logic                result_valid,
    output uafc_pkg::status_t   status
);
    import uafc_pkg::*;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic             sync_reg,  sync_next;
    logic [7:0]       class_reg, class_next;
    logic [7:0]       id_reg,    id_next;
    logic [7:0]       held0_reg, held1_reg;
    logic [7:0]       suma_reg,  suma_next;
    logic [7:0]       sumb_reg,  sumb_next;
    logic             too_short;

    // Header capture and running sums for the current byte
    always_comb begin
        sync_next  = sync_reg;
        class_next = class_reg;
        id_next    = id_reg;
        case (pos_reg)
            4'd0:    sync_next  = (rx_byte == SYNC_FIRST);
            4'd1:    sync_next  = sync_reg && (rx_byte == SYNC_SECOND);
            4'd2:    class_next = rx_byte;
            4'd3:    id_next    = rx_byte;
            default: ;
        endcase
        // byte two places back is now known to lie inside the summed range
        if (pos_reg >= 4'd4) begin
            suma_next = suma_reg + held0_reg;
            sumb_next = sumb_reg + suma_next;
        end else begin
            suma_next = suma_reg;
            sumb_next = sumb_reg;
        end
        pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 4'd1;
    end

    assign too_short = (pos_reg < POS_W'(MIN_FRAME_LEN - 1));

    // Status decision on the last byte, checks in priority order
    always_comb begin
        if (too_short || !sync_next)
            status = ST_NOT_UBX;
        else if (suma_next != held1_reg || sumb_next != rx_byte)
            status = ST_CHECKSUM;
        else if (class_next != cfg.ack_class)
            status = ST_CLASS;
        else if (id_next == cfg.ack_id)
            status = ST_ACK;
        else if (id_next == cfg.nak_id)
            status = ST_NAK;
        else
            status = ST_ID;
    end

    assign result_valid = byte_en && end_of_frame;

    // Frame state: cleared after reset and after each last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || result_valid) begin
            pos_reg   <= '0;
            sync_reg  <= 1'b1;
            class_reg <= '0;
            id_reg    <= '0;
            held0_reg <= '0;
            held1_reg <= '0;
            suma_reg  <= '0;
            sumb_reg  <= '0;
        end else if (byte_en) begin
            pos_reg   <= pos_next;
            sync_reg  <= sync_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            held0_reg <= held1_reg;
            held1_reg <= rx_byte;
            suma_reg  <= suma_next;
            sumb_reg  <= sumb_next;
        end
    end

endmodule

// ===== rtl/ubx_ack_frame_checker.sv =====
// Top level of the UBX acknowledge frame checker.
// Instantiates uafc_regs and uafc_frame; depends on uafc_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready, s_rx_byte, s_end_of_frame) carries one
//   received frame byte per word; s_end_of_frame marks the last byte.
//   Result channel (m_valid/m_ready, m_status) carries one status word per
//   frame: 0 ack, 1 nak, 2 not UBX, 3 checksum bad, 4 wrong class, 5 wrong id.
//   APB port sets ack_class (0x0), ack_id (0x4), nak_id (0x8).
// Timing and throughput:
//   One byte per cycle, but a last byte stalls while a result is held. The
//   status word appears in the cycle after the last byte is accepted, from the
//   result register. The running Fletcher sum updates per byte from the fifth on.
// Reset:
//   aresetn (synchronous, active low) clears the frame state, empties the
//   result register and loads the register defaults (5, 1, 0).
// Stall:
//   Non-final bytes are always taken. A last byte is taken only when the
//   result register is empty or is being drained in the same cycle.
module ubx_ack_frame_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    input  logic                         s_end_of_frame,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_status,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [uafc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import uafc_pkg::*;

    cfg_t    cfg;
    logic    byte_en;
    logic    result_valid;
    status_t status;
    logic    m_valid_reg;
    status_t m_status_reg;

    uafc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Only a last byte needs room in the result register
    assign s_ready = !s_end_of_frame || !m_valid_reg || m_ready;
    assign byte_en = s_valid && s_ready;

    uafc_frame u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_en      (byte_en),
        .rx_byte      (s_rx_byte),
        .end_of_frame (s_end_of_frame),
        .cfg          (cfg),
        .result_valid (result_valid),
        .status       (status)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_valid) begin
            m_status_reg <= status;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

endmodule

// ===== rtl/uafc_checker.sv =====
// Port-level checks for the UBX acknowledge frame checker.
// Bound to ubx_ack_frame_checker; uses no package items.
module uafc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_end_of_frame,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic       pready
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result word changed while stalled");

    // Every accepted last byte yields a result next cycle
    a_eof_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_frame |=> m_valid)
        else $error("no result after last byte");

    // A new result appears only after a last byte was taken
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid && !m_ready) |->
            $past(s_valid && s_ready && s_end_of_frame))
        else $error("result without a last byte");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != 3'd6 && m_status != 3'd7))
        else $error("undefined status code");

    // Non-final bytes are never stalled
    a_body_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_end_of_frame |-> s_ready && pready)
        else $error("non-final byte stalled");

endmodule

bind ubx_ack_frame_checker uafc_checker u_uafc_checker (.*);
